>>> rtl/core/orn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orn_pkg: shared types and constants of the occupancy relay node
// Event and result payloads, register map, function and report codes.
// ----------------------------------------------------------------------------
package orn_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Configuration register map.
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD    = 4'd1;

  localparam logic [7:0]  TPS_RESET    = 8'd100;
  localparam logic [15:0] PERIOD_RESET = 16'd600;
  localparam logic [7:0]  DELAY_RESET  = 8'd10;

  // Received function numbers.
  localparam logic [7:0] FN_SET       = 8'd20;
  localparam logic [7:0] FN_SET_REPLY = 8'd22;
  localparam logic [7:0] FN_STATUS    = 8'd50;

  // Event kinds.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SENSOR = 2'd1,
    CMD_RX     = 2'd2
  } cmd_e;

  // Report kinds.
  typedef enum logic [1:0] {
    KIND_PERIODIC  = 2'd0,
    KIND_PRESENCE  = 2'd1,
    KIND_CMD_REPLY = 2'd2,
    KIND_STATUS    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] command;
    logic       pir_level;
    logic [7:0] func_code;
    logic [7:0] relay_a_req;
    logic [7:0] relay_b_req;
    logic [7:0] relay_c_req;
    logic [7:0] relay_d_req;
    logic [7:0] delay_req;
  } in_item_t;

  typedef struct packed {
    logic       report_valid;
    logic [1:0] report_kind;
    logic [3:0] relay_states;
    logic       sensor_level;
    logic       occupied;
    logic [7:0] delay_minutes_out;
    logic       save_delay;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  ticks_per_second;
    logic [15:0] report_period_seconds;
  } cfg_t;

endpackage

>>> rtl/core/orn_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orn_cfg: configuration registers
// Holds the tick prescale and the periodic report interval.
// ----------------------------------------------------------------------------
module orn_cfg import orn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  logic [7:0]  tps_r;
  logic [15:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r    <= TPS_RESET;
      period_r <= PERIOD_RESET;
    end else if (wr_en) begin
      // Writes to unknown indexes fall through and change nothing.
      if (wr_index == REG_TICKS_PER_SECOND) begin
        tps_r <= wr_data[7:0];
      end
      if (wr_index == REG_REPORT_PERIOD) begin
        period_r <= wr_data[15:0];
      end
    end
  end

  assign cfg.ticks_per_second      = tps_r;
  assign cfg.report_period_seconds = period_r;

endmodule

>>> rtl/core/orn_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orn_engine: event processing and node state
// Updates occupancy, timers and relays for one event and forms its result.
// ----------------------------------------------------------------------------
module orn_engine import orn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      push,
  input  in_item_t  item,
  output out_item_t result
);

  logic        last_r,    last_nxt;
  logic        present_r, present_nxt;
  logic        vac_on_r,  vac_on_nxt;
  logic [7:0]  presc_r,   presc_nxt;
  logic [15:0] rsec_r,    rsec_nxt;
  logic [13:0] vsec_r,    vsec_nxt;
  logic [7:0]  delay_r,   delay_nxt;
  logic [3:0]  relay_r,   relay_nxt;

  logic        rep;
  kind_e       kind;
  logic        save;
  logic [8:0]  tick_sum;
  logic [16:0] rep_sum;
  logic [14:0] vac_sum;
  logic [13:0] vac_limit;

  always_comb begin
    last_nxt    = last_r;
    present_nxt = present_r;
    vac_on_nxt  = vac_on_r;
    presc_nxt   = presc_r;
    rsec_nxt    = rsec_r;
    vsec_nxt    = vsec_r;
    delay_nxt   = delay_r;
    relay_nxt   = relay_r;
    rep         = 1'b0;
    kind        = KIND_PERIODIC;
    save        = 1'b0;
    tick_sum    = {1'b0, presc_r} + 9'd1;
    rep_sum     = {1'b0, rsec_r} + 17'd1;
    vac_sum     = {1'b0, vsec_r} + 15'd1;
    // Timeout in seconds is minutes * 60 = minutes * 64 - minutes * 4.
    vac_limit   = {delay_r, 6'b0} - {4'b0, delay_r, 2'b0};

    case (item.command)
      CMD_TICK: begin
        if (tick_sum >= {1'b0, cfg.ticks_per_second}) begin
          presc_nxt = '0;
          if (rep_sum >= {1'b0, cfg.report_period_seconds}) begin
            rsec_nxt = '0;
            rep      = 1'b1;
            kind     = KIND_PERIODIC;
          end else begin
            rsec_nxt = rep_sum[15:0];
          end
          // A vacancy timeout on the same second overrides the periodic report.
          if (vac_on_r) begin
            if (vac_sum >= {1'b0, vac_limit}) begin
              vac_on_nxt  = 1'b0;
              vsec_nxt    = '0;
              present_nxt = 1'b0;
              rep         = 1'b1;
              kind        = KIND_PRESENCE;
            end else begin
              vsec_nxt = vac_sum[13:0];
            end
          end
        end else begin
          presc_nxt = tick_sum[7:0];
        end
      end
      CMD_SENSOR: begin
        if (item.pir_level != last_r) begin
          vsec_nxt = '0;
          last_nxt = item.pir_level;
          if (item.pir_level) begin
            vac_on_nxt = 1'b0;
            if (!present_r) begin
              present_nxt = 1'b1;
              rep         = 1'b1;
              kind        = KIND_PRESENCE;
            end
          end else begin
            vac_on_nxt = 1'b1;
          end
        end
      end
      CMD_RX: begin
        if (item.func_code == FN_SET || item.func_code == FN_SET_REPLY) begin
          relay_nxt = {|item.relay_d_req, |item.relay_c_req,
                       |item.relay_b_req, |item.relay_a_req};
          if (item.delay_req != delay_r) begin
            delay_nxt = item.delay_req;
            save      = 1'b1;
          end
          if (item.func_code == FN_SET_REPLY) begin
            rep  = 1'b1;
            kind = KIND_CMD_REPLY;
          end
        end else if (item.func_code == FN_STATUS) begin
          rep  = 1'b1;
          kind = KIND_STATUS;
        end
      end
      default: begin
      end
    endcase

    // Any report restarts the periodic interval.
    if (rep) begin
      rsec_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= 1'b0;
      present_r <= 1'b0;
      vac_on_r  <= 1'b0;
      presc_r   <= '0;
      rsec_r    <= '0;
      vsec_r    <= '0;
      delay_r   <= DELAY_RESET;
      relay_r   <= '0;
    end else if (push) begin
      last_r    <= last_nxt;
      present_r <= present_nxt;
      vac_on_r  <= vac_on_nxt;
      presc_r   <= presc_nxt;
      rsec_r    <= rsec_nxt;
      vsec_r    <= vsec_nxt;
      delay_r   <= delay_nxt;
      relay_r   <= relay_nxt;
    end
  end

  assign result.report_valid      = rep;
  assign result.report_kind       = rep ? kind : KIND_PERIODIC;
  assign result.relay_states      = relay_nxt;
  assign result.sensor_level      = last_nxt;
  assign result.occupied          = present_nxt;
  assign result.delay_minutes_out = delay_nxt;
  assign result.save_delay        = save;

endmodule

>>> rtl/core/orn_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orn_out_buf: result register with skid stage
// Holds results until the receiver takes them; stalls the input when full.
// ----------------------------------------------------------------------------
module orn_out_buf import orn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      main_valid_r;
  out_item_t main_data_r;
  logic      skid_valid_r;
  out_item_t skid_data_r;
  logic      pop;

  assign pop = main_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // Input is stalled while the skid stage holds a result.
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_data_r <= push_data;
      end else begin
        main_data_r <= push_data;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_item  = main_data_r;

endmodule

>>> rtl/core/occupancy_relay_node_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_relay_node_unit: occupancy and relay node
// Input channel (in_valid / in_stall / in_item) carries one event per
// transfer: a timer tick, a motion sensor sample or a received command.
// Every event yields exactly one result on the output channel
// (out_valid / out_stall / out_item) showing the node state after the event
// and whether a status report goes out.
// The state is updated at the input transfer edge, where the result is written
// into the result register, or into the skid stage while that register is
// held. One event is taken per cycle while in_stall is low; the state update
// is a single short pass of logic ahead of the result register.
// When the receiver stalls, one extra result is held in a skid stage and
// in_stall rises from the next cycle until the receiver takes a result.
// The cfg port (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; index 0 is ticks per second, index 1 the report period.
// Synchronous reset restores all state and registers to their defaults and
// empties the output.
// ----------------------------------------------------------------------------
module occupancy_relay_node_unit import orn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  out_item_t result;
  logic      push;
  logic      full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign push      = in_valid && !full;

  orn_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  orn_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .push   (push),
    .item   (in_item),
    .result (result)
  );

  orn_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> verif/tb_occupancy_relay_node_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_occupancy_relay_node_unit: self-checking bench for the occupancy node
// A short table of directed events runs first, followed by random event
// phases, each with its own register setting and one of three idle patterns.
// A behavioral copy of the node predicts each result the table does not fix;
// each result transfer is compared by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_occupancy_relay_node_unit;
  import orn_pkg::*;

  localparam int          CYCLE_LIMIT  = 100000;
  localparam int          NUM_PHASES   = 10;
  localparam int          PHASE_EVENTS = 40;
  localparam int          HOLD_CYCLES  = 64;
  localparam int unsigned SECS_PER_MIN = 60;

  localparam logic [1:0]           CMD_UNUSED   = 2'd3;
  localparam logic [7:0]           FN_UNUSED    = 8'd21;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd15;

  typedef struct packed {
    in_item_t  item;
    logic      fixed;
    out_item_t want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Side information that travels with each offered event.
  logic      drv_fixed = 1'b0;
  out_item_t drv_want = '0;

  // Behavioral copy of the node: registers and state.
  logic [7:0]  tps_q      = TPS_RESET;
  logic [15:0] period_q   = PERIOD_RESET;
  logic        sensor_q   = 1'b0;
  logic        present_q  = 1'b0;
  logic        counting_q = 1'b0;
  logic [7:0]  prescale_q = '0;
  logic [15:0] rep_secs_q = '0;
  logic [13:0] vac_secs_q = '0;
  logic [7:0]  delay_q    = DELAY_RESET;
  logic [3:0]  relays_q   = '0;

  out_item_t   pending_status[$];
  plan_row_t   directed_plan[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          pressure_on = 1'b0;
  bit          pressure_done = 1'b0;
  int          hold_left = 0;

  int unsigned tps_plan[NUM_PHASES]    = '{1, 255, 2, 0, 3, 100, 1, 4, 0, 2};
  int unsigned period_plan[NUM_PHASES] = '{1, 65535, 3, 0, 10, 600, 2, 1, 65535, 5};

  occupancy_relay_node_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic in_item_t ev_of(input logic [1:0] cmd, input logic pir,
                                     input logic [7:0] fn, input logic [7:0] ra,
                                     input logic [7:0] rb, input logic [7:0] rc,
                                     input logic [7:0] rd, input logic [7:0] dly);
    in_item_t e;
    e.command     = cmd;
    e.pir_level   = pir;
    e.func_code   = fn;
    e.relay_a_req = ra;
    e.relay_b_req = rb;
    e.relay_c_req = rc;
    e.relay_d_req = rd;
    e.delay_req   = dly;
    return e;
  endfunction

  function automatic out_item_t status_of(input logic rv, input logic [1:0] kind,
                                          input logic [3:0] relays, input logic sens,
                                          input logic occ, input logic [7:0] dly,
                                          input logic save);
    out_item_t r;
    r.report_valid      = rv;
    r.report_kind       = kind;
    r.relay_states      = relays;
    r.sensor_level      = sens;
    r.occupied          = occ;
    r.delay_minutes_out = dly;
    r.save_delay        = save;
    return r;
  endfunction

  // Advances the behavioral copy by one event and returns the status it shows.
  function automatic out_item_t advance_node(input in_item_t ev);
    out_item_t   r;
    logic        rep;
    logic [1:0]  kind;
    logic        save;
    int unsigned nxt;
    rep  = 1'b0;
    kind = KIND_PERIODIC;
    save = 1'b0;
    case (ev.command)
      CMD_TICK: begin
        nxt = prescale_q + 1;
        if (nxt >= tps_q) begin
          prescale_q = '0;
          nxt = rep_secs_q + 1;
          if (nxt >= period_q) begin
            rep_secs_q = '0;
            rep = 1'b1;
            kind = KIND_PERIODIC;
          end else begin
            rep_secs_q = nxt[15:0];
          end
          // A vacancy timeout in the same second overrides the periodic report.
          if (counting_q) begin
            nxt = vac_secs_q + 1;
            if (nxt >= int'(delay_q) * SECS_PER_MIN) begin
              counting_q = 1'b0;
              vac_secs_q = '0;
              present_q = 1'b0;
              rep = 1'b1;
              kind = KIND_PRESENCE;
            end else begin
              vac_secs_q = nxt[13:0];
            end
          end
        end else begin
          prescale_q = nxt[7:0];
        end
      end
      CMD_SENSOR: begin
        if (ev.pir_level != sensor_q) begin
          vac_secs_q = '0;
          if (ev.pir_level) begin
            counting_q = 1'b0;
            if (!present_q) begin
              present_q = 1'b1;
              rep = 1'b1;
              kind = KIND_PRESENCE;
            end
          end else begin
            counting_q = 1'b1;
          end
          sensor_q = ev.pir_level;
        end
      end
      CMD_RX: begin
        if (ev.func_code == FN_SET || ev.func_code == FN_SET_REPLY) begin
          relays_q = {ev.relay_d_req != 0, ev.relay_c_req != 0,
                      ev.relay_b_req != 0, ev.relay_a_req != 0};
          if (ev.delay_req != delay_q) begin
            delay_q = ev.delay_req;
            save = 1'b1;
          end
          if (ev.func_code == FN_SET_REPLY) begin
            rep = 1'b1;
            kind = KIND_CMD_REPLY;
          end
        end else if (ev.func_code == FN_STATUS) begin
          rep = 1'b1;
          kind = KIND_STATUS;
        end
      end
      default: ;
    endcase
    if (rep) rep_secs_q = '0;
    r = status_of(rep, rep ? kind : KIND_PERIODIC, relays_q, sensor_q, present_q,
                  delay_q, save);
    return r;
  endfunction

  function automatic in_item_t rand_event();
    in_item_t    e;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) e.command = CMD_TICK;
    else if (pick < 75) e.command = CMD_SENSOR;
    else if (pick < 95) e.command = CMD_RX;
    else e.command = CMD_UNUSED;
    e.pir_level = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: e.func_code = FN_SET;
      1: e.func_code = FN_SET_REPLY;
      2: e.func_code = FN_STATUS;
      default: e.func_code = 8'($urandom_range(255));
    endcase
    e.relay_a_req = $urandom_range(1) ? 8'($urandom_range(255)) : 8'd0;
    e.relay_b_req = $urandom_range(1) ? 8'($urandom_range(255)) : 8'd0;
    e.relay_c_req = $urandom_range(1) ? 8'($urandom_range(255)) : 8'd0;
    e.relay_d_req = $urandom_range(1) ? 8'($urandom_range(255)) : 8'd0;
    // Short timeouts keep vacancy expiry within reach of a phase.
    e.delay_req = ($urandom_range(9) < 7) ? 8'($urandom_range(2)) : 8'($urandom_range(255));
    return e;
  endfunction

  task automatic add_row(input in_item_t item, input logic fixed, input out_item_t want);
    plan_row_t row;
    row.item  = item;
    row.fixed = fixed;
    row.want  = want;
    directed_plan.push_back(row);
  endtask

  task automatic offer_event(input in_item_t item, input logic fixed,
                             input out_item_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_item   <= item;
    drv_fixed <= fixed;
    drv_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when pressure is requested.
  always @(posedge clk) begin
    if (pressure_on && !pressure_done) begin
      hold_left = HOLD_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TICKS_PER_SECOND) tps_q = cfg_data[7:0];
        else if (cfg_index == REG_REPORT_PERIOD) period_q = cfg_data;
      end
      if (in_valid && !in_stall) begin
        want = advance_node(in_item);
        if (drv_fixed) want = drv_want;
        pending_status.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_status.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected, got %h", $time, out_item);
          mismatches++;
        end else begin
          want = pending_status.pop_front();
          check_field("report_valid", want.report_valid, out_item.report_valid);
          check_field("report_kind", want.report_kind, out_item.report_kind);
          check_field("relay_states", want.relay_states, out_item.relay_states);
          check_field("sensor_level", want.sensor_level, out_item.sensor_level);
          check_field("occupied", want.occupied, out_item.occupied);
          check_field("delay_minutes_out", want.delay_minutes_out,
                      out_item.delay_minutes_out);
          check_field("save_delay", want.save_delay, out_item.save_delay);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // Directed events run with every tick a second and a report every second.
    add_row(ev_of(CMD_RX, 1'b0, FN_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b1, KIND_STATUS, 4'h0, 1'b0, 1'b0, DELAY_RESET, 1'b0));
    add_row(ev_of(CMD_RX, 1'b0, FN_SET_REPLY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
            status_of(1'b1, KIND_CMD_REPLY, 4'hF, 1'b0, 1'b0, 8'd255, 1'b1));
    add_row(ev_of(CMD_RX, 1'b0, FN_SET, 8'h01, 8'h00, 8'h80, 8'h00, 8'h00), 1'b1,
            status_of(1'b0, KIND_PERIODIC, 4'b0101, 1'b0, 1'b0, 8'd0, 1'b1));
    // Same delay again: the save flag stays low.
    add_row(ev_of(CMD_RX, 1'b0, FN_SET, 8'h00, 8'h02, 8'h00, 8'h40, 8'h00), 1'b1,
            status_of(1'b0, KIND_PERIODIC, 4'b1010, 1'b0, 1'b0, 8'd0, 1'b0));
    add_row(ev_of(CMD_RX, 1'b0, FN_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd7), 1'b1,
            status_of(1'b0, KIND_PERIODIC, 4'b1010, 1'b0, 1'b0, 8'd0, 1'b0));
    add_row(ev_of(CMD_UNUSED, 1'b1, FN_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'd3), 1'b1,
            status_of(1'b0, KIND_PERIODIC, 4'b1010, 1'b0, 1'b0, 8'd0, 1'b0));
    add_row(ev_of(CMD_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b1, KIND_PERIODIC, 4'b1010, 1'b0, 1'b0, 8'd0, 1'b0));
    add_row(ev_of(CMD_SENSOR, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b1, KIND_PRESENCE, 4'b1010, 1'b1, 1'b1, 8'd0, 1'b0));
    add_row(ev_of(CMD_SENSOR, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b0, KIND_PERIODIC, 4'b1010, 1'b1, 1'b1, 8'd0, 1'b0));
    add_row(ev_of(CMD_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b1, KIND_PERIODIC, 4'b1010, 1'b1, 1'b1, 8'd0, 1'b0));
    add_row(ev_of(CMD_SENSOR, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b0, KIND_PERIODIC, 4'b1010, 1'b0, 1'b1, 8'd0, 1'b0));
    // Zero timeout expires on the first counted second and beats the periodic report.
    add_row(ev_of(CMD_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b1, KIND_PRESENCE, 4'b1010, 1'b0, 1'b0, 8'd0, 1'b0));
    add_row(ev_of(CMD_SENSOR, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b0, KIND_PERIODIC, 4'b1010, 1'b0, 1'b0, 8'd0, 1'b0));
    add_row(ev_of(CMD_RX, 1'b0, FN_SET_REPLY, 8'h00, 8'h00, 8'h00, 8'h00, 8'd1), 1'b1,
            status_of(1'b1, KIND_CMD_REPLY, 4'h0, 1'b0, 1'b0, 8'd1, 1'b1));
    add_row(ev_of(CMD_SENSOR, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b1, KIND_PRESENCE, 4'h0, 1'b1, 1'b1, 8'd1, 1'b0));
    add_row(ev_of(CMD_SENSOR, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b0, KIND_PERIODIC, 4'h0, 1'b0, 1'b1, 8'd1, 1'b0));
    add_row(ev_of(CMD_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b1, KIND_PERIODIC, 4'h0, 1'b0, 1'b1, 8'd1, 1'b0));
    add_row(ev_of(CMD_RX, 1'b0, FN_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            status_of(1'b1, KIND_STATUS, 4'h0, 1'b0, 1'b1, 8'd1, 1'b0));
    // Field extremes with unused fields set, checked by the predictor.
    add_row(ev_of(CMD_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
    add_row(ev_of(CMD_SENSOR, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
    add_row(ev_of(CMD_RX, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
    add_row(ev_of(CMD_RX, 1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
    add_row(ev_of(CMD_UNUSED, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 31;
    rx_idle_pct = 49;
    write_reg(REG_TICKS_PER_SECOND, 16'h0000);
    write_reg(REG_REPORT_PERIOD, 16'h0000);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    foreach (directed_plan[i])
      offer_event(directed_plan[i].item, directed_plan[i].fixed, directed_plan[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      if (p < 4) begin
        tx_idle_pct = 31;
        rx_idle_pct = 49;
      end else if (p < 7) begin
        tx_idle_pct = 49;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // Upper data bits are don't-care for the 8-bit register.
      write_reg(REG_TICKS_PER_SECOND, {8'($urandom_range(255)), 8'(tps_plan[p])});
      write_reg(REG_REPORT_PERIOD, 16'(period_plan[p]));
      // A long receiver hold-off while the sender keeps offering fills the node.
      if (p == 7) pressure_on = 1'b1;
      for (int n = 0; n < PHASE_EVENTS; n++)
        offer_event(rand_event(), 1'b0, '0);
    end

    wait_quiet();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
